/* hw/rtl/qsm_pkg.sv */
// ============================================================================
// Quaternion to skinning matrix package
// Shared transaction types, fixed-point constants and rounding helpers.
// ============================================================================
package qsm_pkg;

    localparam int unsigned EntryWidth = 35;
    localparam int unsigned ShiftWidth = 52;

    localparam logic signed [EntryWidth-1:0] OneQ28     = 35'sd268435456;
    localparam logic signed [EntryWidth-1:0] HalfEntry  = 35'sd8192;
    localparam logic signed [ShiftWidth-1:0] HalfShift  = 52'sd8192;
    localparam logic signed [20:0]           Q14Max     = 21'sd32767;
    localparam logic signed [20:0]           Q14Min     = -21'sd32768;
    localparam logic signed [37:0]           Q16Max     = 38'sd2147483647;
    localparam logic signed [37:0]           Q16Min     = -38'sd2147483648;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] rest_x;
        logic signed [31:0] rest_y;
        logic signed [31:0] rest_z;
    } item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] rest_x;
        logic signed [31:0] rest_y;
        logic signed [31:0] rest_z;
    } joint_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } matrix_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } result_t;

    // Round half up from Q7.28 to Q2.14 and saturate.
    function automatic logic signed [15:0] round_sat16(input logic signed [EntryWidth-1:0] v);
        logic signed [EntryWidth-1:0] t;
        logic signed [20:0]           r;
        t = v + HalfEntry;
        r = 21'(t >>> 14);
        if (r > Q14Max)
        begin
            return 16'sh7fff;
        end
        if (r < Q14Min)
        begin
            return -16'sh8000;
        end
        return r[15:0];
    endfunction

    // Round half up from Q.30 to Q16.16 and saturate.
    function automatic logic signed [31:0] round_sat32(input logic signed [ShiftWidth-1:0] v);
        logic signed [ShiftWidth-1:0] t;
        logic signed [37:0]           r;
        t = v + HalfShift;
        r = 38'(t >>> 14);
        if (r > Q16Max)
        begin
            return 32'sh7fffffff;
        end
        if (r < Q16Min)
        begin
            return -32'sh80000000;
        end
        return r[31:0];
    endfunction

endpackage

/* hw/rtl/qsm_entry.sv */
// ============================================================================
// Rotation entry stages
// Forms the quaternion products, then the nine rounded and saturated
// rotation entries, over two register stages.
// ============================================================================
module qsm_entry
    import qsm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  item_t   in_item,
    output logic    out_valid,
    output matrix_t out_mat,
    output joint_t  out_joint
);

    logic                valid_a_reg;
    logic signed [31:0]  xx_reg, xy_reg, xz_reg, xw_reg, yy_reg;
    logic signed [31:0]  yz_reg, yw_reg, zz_reg, zw_reg;
    logic signed [31:0]  xx_next, xy_next, xz_next, xw_next, yy_next;
    logic signed [31:0]  yz_next, yw_next, zz_next, zw_next;
    joint_t              joint_a_reg;
    joint_t              joint_a_next;

    logic                valid_b_reg;
    matrix_t             mat_b_reg;
    matrix_t             mat_b_next;
    joint_t              joint_b_reg;

    logic signed [EntryWidth-1:0] xx_e, xy_e, xz_e, xw_e, yy_e, yz_e, yw_e, zz_e, zw_e;

    always_comb
    begin
        xx_next = in_item.quat_x * in_item.quat_x;
        xy_next = in_item.quat_x * in_item.quat_y;
        xz_next = in_item.quat_x * in_item.quat_z;
        xw_next = in_item.quat_x * in_item.quat_w;
        yy_next = in_item.quat_y * in_item.quat_y;
        yz_next = in_item.quat_y * in_item.quat_z;
        yw_next = in_item.quat_y * in_item.quat_w;
        zz_next = in_item.quat_z * in_item.quat_z;
        zw_next = in_item.quat_z * in_item.quat_w;
        joint_a_next.pos_x  = in_item.pos_x;
        joint_a_next.pos_y  = in_item.pos_y;
        joint_a_next.pos_z  = in_item.pos_z;
        joint_a_next.rest_x = in_item.rest_x;
        joint_a_next.rest_y = in_item.rest_y;
        joint_a_next.rest_z = in_item.rest_z;
    end

    always_comb
    begin
        xx_e = EntryWidth'(xx_reg);
        xy_e = EntryWidth'(xy_reg);
        xz_e = EntryWidth'(xz_reg);
        xw_e = EntryWidth'(xw_reg);
        yy_e = EntryWidth'(yy_reg);
        yz_e = EntryWidth'(yz_reg);
        yw_e = EntryWidth'(yw_reg);
        zz_e = EntryWidth'(zz_reg);
        zw_e = EntryWidth'(zw_reg);
        mat_b_next.m00 = round_sat16(OneQ28 - ((yy_e + zz_e) <<< 1));
        mat_b_next.m01 = round_sat16((xy_e + zw_e) <<< 1);
        mat_b_next.m02 = round_sat16((xz_e - yw_e) <<< 1);
        mat_b_next.m10 = round_sat16((xy_e - zw_e) <<< 1);
        mat_b_next.m11 = round_sat16(OneQ28 - ((xx_e + zz_e) <<< 1));
        mat_b_next.m12 = round_sat16((yz_e + xw_e) <<< 1);
        mat_b_next.m20 = round_sat16((xz_e + yw_e) <<< 1);
        mat_b_next.m21 = round_sat16((yz_e - xw_e) <<< 1);
        mat_b_next.m22 = round_sat16(OneQ28 - ((xx_e + yy_e) <<< 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        xx_reg      <= xx_next;
        xy_reg      <= xy_next;
        xz_reg      <= xz_next;
        xw_reg      <= xw_next;
        yy_reg      <= yy_next;
        yz_reg      <= yz_next;
        yw_reg      <= yw_next;
        zz_reg      <= zz_next;
        zw_reg      <= zw_next;
        joint_a_reg <= joint_a_next;
        mat_b_reg   <= mat_b_next;
        joint_b_reg <= joint_a_reg;
    end

    assign out_valid = valid_b_reg;
    assign out_mat   = mat_b_reg;
    assign out_joint = joint_b_reg;

endmodule

/* hw/rtl/qsm_shift.sv */
// ============================================================================
// Translation stages
// Rotates the rest joint by the matrix, subtracts it from the current joint,
// then rounds and saturates, over three register stages.
// ============================================================================
module qsm_shift
    import qsm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  matrix_t in_mat,
    input  joint_t  in_joint,
    output logic    out_valid,
    output result_t out_result
);

    logic                valid_c_reg;
    logic signed [47:0]  pa_reg [3];
    logic signed [47:0]  pb_reg [3];
    logic signed [47:0]  pc_reg [3];
    logic signed [47:0]  pa_next [3];
    logic signed [47:0]  pb_next [3];
    logic signed [47:0]  pc_next [3];
    logic signed [31:0]  pos_c_reg [3];
    matrix_t             mat_c_reg;

    logic                          valid_d_reg;
    logic signed [ShiftWidth-1:0]  diff_reg [3];
    logic signed [ShiftWidth-1:0]  diff_next [3];
    matrix_t                       mat_d_reg;

    logic     valid_e_reg;
    result_t  result_reg;
    result_t  result_next;

    always_comb
    begin
        pa_next[0] = in_mat.m00 * in_joint.rest_x;
        pb_next[0] = in_mat.m10 * in_joint.rest_y;
        pc_next[0] = in_mat.m20 * in_joint.rest_z;
        pa_next[1] = in_mat.m01 * in_joint.rest_x;
        pb_next[1] = in_mat.m11 * in_joint.rest_y;
        pc_next[1] = in_mat.m21 * in_joint.rest_z;
        pa_next[2] = in_mat.m02 * in_joint.rest_x;
        pb_next[2] = in_mat.m12 * in_joint.rest_y;
        pc_next[2] = in_mat.m22 * in_joint.rest_z;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff_next[i] = (ShiftWidth'(pos_c_reg[i]) <<< 14)
                         - (ShiftWidth'(pa_reg[i]) + ShiftWidth'(pb_reg[i])
                            + ShiftWidth'(pc_reg[i]));
        end
    end

    always_comb
    begin
        result_next.m00     = mat_d_reg.m00;
        result_next.m01     = mat_d_reg.m01;
        result_next.m02     = mat_d_reg.m02;
        result_next.m10     = mat_d_reg.m10;
        result_next.m11     = mat_d_reg.m11;
        result_next.m12     = mat_d_reg.m12;
        result_next.m20     = mat_d_reg.m20;
        result_next.m21     = mat_d_reg.m21;
        result_next.m22     = mat_d_reg.m22;
        result_next.shift_x = round_sat32(diff_reg[0]);
        result_next.shift_y = round_sat32(diff_reg[1]);
        result_next.shift_z = round_sat32(diff_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
            valid_e_reg <= 1'b0;
        end
        else
        begin
            valid_c_reg <= in_valid;
            valid_d_reg <= valid_c_reg;
            valid_e_reg <= valid_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pa_reg[i]   <= pa_next[i];
            pb_reg[i]   <= pb_next[i];
            pc_reg[i]   <= pc_next[i];
            diff_reg[i] <= diff_next[i];
        end
        pos_c_reg[0] <= in_joint.pos_x;
        pos_c_reg[1] <= in_joint.pos_y;
        pos_c_reg[2] <= in_joint.pos_z;
        mat_c_reg    <= in_mat;
        mat_d_reg    <= mat_c_reg;
        result_reg   <= result_next;
    end

    assign out_valid  = valid_e_reg;
    assign out_result = result_reg;

endmodule

/* hw/rtl/quaternion_to_skinning_matrix.sv */
// ============================================================================
// Quaternion to skinning matrix
// Turns one bone transaction (quaternion, current and rest joint) into the
// rotation entries and translation column of its skinning matrix.
// ============================================================================
// A transaction is taken at a rising edge where start is high and busy is low.
// busy is high only during reset and in the first cycle after it; the block
// then takes a new transaction in every cycle.
// The result appears on result for exactly one cycle, marked by done, after
// its transaction has passed the five register stages: quaternion products,
// entry rounding, rest-joint products, translation difference, and final
// rounding with the output register.
// Throughput is one transaction per cycle, one result per transaction, in
// the order taken.
// The receiver cannot stall: each result must be captured in the cycle that
// done is high.
// Reset clears all valid bits, so no result is issued for anything in flight.
// ============================================================================
module quaternion_to_skinning_matrix
    import qsm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    done,
    output result_t result
);

    logic    busy_reg;
    logic    accept;
    logic    mat_valid;
    matrix_t mat;
    joint_t  joint;

    assign accept = start && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    qsm_entry u_entry (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_item   (item),
        .out_valid (mat_valid),
        .out_mat   (mat),
        .out_joint (joint)
    );

    qsm_shift u_shift (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (mat_valid),
        .in_mat     (mat),
        .in_joint   (joint),
        .out_valid  (done),
        .out_result (result)
    );

    assign busy = busy_reg;

`ifndef NO_ASSERTIONS
    // done follows each accepted transaction, and no other.
    assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(accept, 5))
        else $error("done does not follow an accepted transaction by five cycles");

    // Once released after reset, busy never rises again.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> $past(busy))
        else $error("busy rose after reset");

    // The diagonal entries are one minus a non-negative term.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.m00 <= 16'sd16384) && (result.m11 <= 16'sd16384)
                 && (result.m22 <= 16'sd16384))
        else $error("diagonal entry above one");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// Quaternion to skinning matrix testbench
// Sends bone transactions (quaternion, current joint, rest joint) to the
// block and checks every result field against an independent fixed-point
// model of the rotation entries and the translation column. A short table
// of directed bones comes first, followed by random bones of mixed shape,
// with random gaps on the sending side and one full drain in the middle.
// ============================================================================
module tb
    import qsm_pkg::*;
();

    localparam int     RandomBones = 1500;
    localparam int     QuietTail   = 300;
    localparam int     CycleLimit  = 200000;
    localparam int     Q1          = 16384;
    localparam int     P1          = 65536;
    localparam longint OneQ4_28    = 64'sd268435456;
    localparam longint Q16Top      = 64'sd2147483647;
    localparam longint Q16Bottom   = -64'sd2147483648;

    typedef struct {
        item_t   bone;
        bit      typed;
        result_t want;
    } bone_row_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    done;
    result_t result;

    result_t   pending_results[$];
    bone_row_t directed_rows[$];
    int        mismatches   = 0;
    int        results_seen = 0;
    int        cycles       = 0;

    quaternion_to_skinning_matrix DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    function automatic longint round_half_up14(longint v);
        return (v + 64'sd8192) >>> 14;
    endfunction

    function automatic logic signed [15:0] entry_q14(longint q28);
        longint r;
        r = round_half_up14(q28);
        if (r > 32767)
        begin
            return 16'sh7fff;
        end
        if (r < -32768)
        begin
            return 16'sh8000;
        end
        return 16'(r);
    endfunction

    function automatic logic signed [31:0] shift_q16(longint pos, longint a, longint b,
                                                     longint c, longint rx, longint ry,
                                                     longint rz);
        longint r;
        r = round_half_up14(pos * 16384 - (a * rx + b * ry + c * rz));
        if (r > Q16Top)
        begin
            return 32'sh7fffffff;
        end
        if (r < Q16Bottom)
        begin
            return 32'sh80000000;
        end
        return 32'(r);
    endfunction

    function automatic result_t skin_matrix_of(item_t bone);
        longint  x, y, z, w, rx, ry, rz;
        result_t res;
        x  = longint'(bone.quat_x);
        y  = longint'(bone.quat_y);
        z  = longint'(bone.quat_z);
        w  = longint'(bone.quat_w);
        rx = longint'(bone.rest_x);
        ry = longint'(bone.rest_y);
        rz = longint'(bone.rest_z);
        res.m00 = entry_q14(OneQ4_28 - 2 * (y * y + z * z));
        res.m01 = entry_q14(2 * (x * y + z * w));
        res.m02 = entry_q14(2 * (x * z - y * w));
        res.m10 = entry_q14(2 * (x * y - z * w));
        res.m11 = entry_q14(OneQ4_28 - 2 * (x * x + z * z));
        res.m12 = entry_q14(2 * (y * z + x * w));
        res.m20 = entry_q14(2 * (x * z + y * w));
        res.m21 = entry_q14(2 * (y * z - x * w));
        res.m22 = entry_q14(OneQ4_28 - 2 * (x * x + y * y));
        res.shift_x = shift_q16(longint'(bone.pos_x), longint'(res.m00), longint'(res.m10),
                                longint'(res.m20), rx, ry, rz);
        res.shift_y = shift_q16(longint'(bone.pos_y), longint'(res.m01), longint'(res.m11),
                                longint'(res.m21), rx, ry, rz);
        res.shift_z = shift_q16(longint'(bone.pos_z), longint'(res.m02), longint'(res.m12),
                                longint'(res.m22), rx, ry, rz);
        return res;
    endfunction

    function automatic item_t make_bone(longint qx, longint qy, longint qz, longint qw,
                                        longint px, longint py, longint pz,
                                        longint rx, longint ry, longint rz);
        item_t bone;
        bone.quat_x = 16'(qx);
        bone.quat_y = 16'(qy);
        bone.quat_z = 16'(qz);
        bone.quat_w = 16'(qw);
        bone.pos_x  = 32'(px);
        bone.pos_y  = 32'(py);
        bone.pos_z  = 32'(pz);
        bone.rest_x = 32'(rx);
        bone.rest_y = 32'(ry);
        bone.rest_z = 32'(rz);
        return bone;
    endfunction

    function automatic result_t make_result(longint m00, longint m01, longint m02,
                                            longint m10, longint m11, longint m12,
                                            longint m20, longint m21, longint m22,
                                            longint sx, longint sy, longint sz);
        result_t res;
        res.m00     = 16'(m00);
        res.m01     = 16'(m01);
        res.m02     = 16'(m02);
        res.m10     = 16'(m10);
        res.m11     = 16'(m11);
        res.m12     = 16'(m12);
        res.m20     = 16'(m20);
        res.m21     = 16'(m21);
        res.m22     = 16'(m22);
        res.shift_x = 32'(sx);
        res.shift_y = 32'(sy);
        res.shift_z = 32'(sz);
        return res;
    endfunction

    function automatic longint corner_value(int bits);
        case ($urandom_range(0, 4))
            0: return 64'sd0;
            1: return 64'sd1;
            2: return -64'sd1;
            3: return -(64'sd1 <<< (bits - 1));
            default: return (64'sd1 <<< (bits - 1)) - 1;
        endcase
    endfunction

    function automatic item_t random_bone();
        item_t bone;
        int    mode;
        mode = $urandom_range(0, 9);
        if (mode <= 1)
        begin
            bone = make_bone($urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        else if (mode == 2)
        begin
            bone = make_bone(corner_value(16), corner_value(16), corner_value(16),
                             corner_value(16), corner_value(32), corner_value(32),
                             corner_value(32), corner_value(32), corner_value(32),
                             corner_value(32));
        end
        else
        begin
            bone = make_bone($urandom_range(0, 32768) - 16384,
                             $urandom_range(0, 32768) - 16384,
                             $urandom_range(0, 32768) - 16384,
                             $urandom_range(0, 32768) - 16384,
                             $urandom_range(0, 33554431) - 16777216,
                             $urandom_range(0, 33554431) - 16777216,
                             $urandom_range(0, 33554431) - 16777216,
                             $urandom_range(0, 33554431) - 16777216,
                             $urandom_range(0, 33554431) - 16777216,
                             $urandom_range(0, 33554431) - 16777216);
        end
        return bone;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at result %0d: %s", results_seen, what);
        mismatches++;
    endtask

    task automatic compare_field(string name, longint got, longint want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    task automatic check_fields(result_t got, result_t want);
        compare_field("m00", longint'(got.m00), longint'(want.m00));
        compare_field("m01", longint'(got.m01), longint'(want.m01));
        compare_field("m02", longint'(got.m02), longint'(want.m02));
        compare_field("m10", longint'(got.m10), longint'(want.m10));
        compare_field("m11", longint'(got.m11), longint'(want.m11));
        compare_field("m12", longint'(got.m12), longint'(want.m12));
        compare_field("m20", longint'(got.m20), longint'(want.m20));
        compare_field("m21", longint'(got.m21), longint'(want.m21));
        compare_field("m22", longint'(got.m22), longint'(want.m22));
        compare_field("shift_x", longint'(got.shift_x), longint'(want.shift_x));
        compare_field("shift_y", longint'(got.shift_y), longint'(want.shift_y));
        compare_field("shift_z", longint'(got.shift_z), longint'(want.shift_z));
    endtask

    task automatic add_row(item_t bone, bit typed = 1'b0, result_t want = '0);
        bone_row_t row;
        row.bone  = bone;
        row.typed = typed;
        row.want  = want;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic send_bone(item_t bone, result_t want);
        start <= 1'b1;
        item  <= bone;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        pending_results.insert(pending_results.size(), want);
    endtask

    task automatic idle_burst(int gap);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no transaction pending");
            end
            else
            begin
                want = pending_results.pop_front();
                check_fields(result, want);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CycleLimit)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        item_t bone;
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;

        add_row(make_bone(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                make_result(Q1, 0, 0, 0, Q1, 0, 0, 0, Q1, 0, 0, 0));
        add_row(make_bone(0, 0, 0, Q1, 5 * P1, -3 * P1, 7 * P1, 2 * P1, P1, -P1), 1'b1,
                make_result(Q1, 0, 0, 0, Q1, 0, 0, 0, Q1, 3 * P1, -4 * P1, 8 * P1));
        add_row(make_bone(0, 0, 0, Q1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h80000000, 32'h80000000, 32'h80000000), 1'b1,
                make_result(Q1, 0, 0, 0, Q1, 0, 0, 0, Q1,
                            32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        add_row(make_bone(0, 0, 0, Q1, 32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 1'b1,
                make_result(Q1, 0, 0, 0, Q1, 0, 0, 0, Q1,
                            32'h80000000, 32'h80000000, 32'h80000000));
        add_row(make_bone(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0, 0, 0), 1'b1,
                make_result(16'h8000, 16'h7fff, 0, 0, 16'h8000, 16'h7fff, 16'h7fff, 0,
                            16'h8000, 0, 0, 0));
        add_row(make_bone(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0, 0, 0, 0));
        add_row(make_bone(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 32'h7fffffff,
                          32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                          32'h80000000));
        add_row(make_bone(16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h80000000,
                          32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                          32'h80000000));
        add_row(make_bone(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 32'h7fffffff,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h7fffffff));
        add_row(make_bone(0, 0, 0, -Q1, P1, 2 * P1, 3 * P1, -P1, 0, P1));
        add_row(make_bone(Q1, 0, 0, 0, P1, 2 * P1, 3 * P1, 4 * P1, 5 * P1, 6 * P1));
        add_row(make_bone(0, Q1, 0, 0, -P1, 2 * P1, -3 * P1, 4 * P1, -5 * P1, 6 * P1));
        add_row(make_bone(0, 0, Q1, 0, 7 * P1, 0, -7 * P1, P1, P1, P1));
        add_row(make_bone(0, 0, 11585, 11585, 10 * P1, 20 * P1, 30 * P1, 3 * P1,
                          -4 * P1, 5 * P1));
        add_row(make_bone(8192, 8192, 8192, 8192, 1, -1, 2, 3, -3, 1));
        add_row(make_bone(1, 1, 0, 0, 0, 0, 0, 1, 1, 1));
        add_row(make_bone(-1, 1, 1, 1, 1, 1, 1, -1, -1, -1));
        add_row(make_bone(64, -64, 91, 45, 8191, -8192, 8193, 3, -5, 7));
        add_row(make_bone(16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0, 32'h55555555,
                          32'haaaaaaaa, 32'h0f0f0f0f, 32'hf0f0f0f0, 32'h33333333,
                          32'hcccccccc));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            send_bone(directed_rows[i].bone,
                      directed_rows[i].typed ? directed_rows[i].want
                                             : skin_matrix_of(directed_rows[i].bone));
            if ($urandom_range(0, 3) == 0)
            begin
                idle_burst($urandom_range(1, 12));
            end
        end

        for (int n = 0; n < RandomBones; n++)
        begin
            if (n == RandomBones / 2)
            begin
                drain_results();
            end
            bone = random_bone();
            send_bone(bone, skin_matrix_of(bone));
            if (n < RandomBones - QuietTail && $urandom_range(0, 3) == 0)
            begin
                idle_burst($urandom_range(1, 12));
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
